/* src/fpm_pkg.sv */
package fpm_pkg;
  localparam int unsigned WordW = 32;
  localparam logic [31:0] InfBits    = 32'h7f80_0000;
  localparam logic [31:0] DefaultNan = 32'hffc0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [9:0]  ExpBias    = 10'd127;
  localparam logic [9:0]  ExpMaxNorm = 10'd254;
  localparam logic [9:0]  MaxDenorm  = 10'd25;

  typedef logic [WordW-1:0] word_t;

  // leading-zero count of a 24-bit value, 0..24
  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(23 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction
endpackage

/* src/fpm_if.sv */
interface fpm_in_if;
  import fpm_pkg::*;
  logic  valid;
  logic  ready;
  word_t operand_a;
  word_t operand_b;
  modport source (output valid, operand_a, operand_b, input ready);
  modport sink (input valid, operand_a, operand_b, output ready);
endinterface

interface fpm_out_if;
  import fpm_pkg::*;
  logic  valid;
  logic  ready;
  word_t product;
  modport source (output valid, product, input ready);
  modport sink (input valid, product, output ready);
endinterface

/* src/fp32_multiplier_rne.sv */
// IEEE-754 binary32 multiplier, round to nearest even, fully pipelined. It takes
// one transaction per cycle when not stalled, through four register stages, the
// last of which drives the product at the output. Stage 1
// classifies operands and normalizes subnormals with a leading-zero count,
// stage 2 multiplies the 24x24 significands, stage 3 normalizes and computes
// the denormalizing shift, stage 4 shifts, rounds and forms the result.
// NaN inputs come back quietened (operand_a first), zero times infinity gives
// 0xffc00000, no exception flags. Backpressure stalls all stages together.
module fp32_multiplier_rne (
  input logic clk,
  input logic rst,
  fpm_in_if.sink  in_ch,
  fpm_out_if.source out_ch
);
  import fpm_pkg::*;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1
  logic        v1, sp1, sgn1;
  word_t       spv1;
  logic [23:0] sa1, sb1;
  logic [9:0]  e1;
  // stage 2
  logic        v2, sp2, sgn2;
  word_t       spv2;
  logic [47:0] m2;
  logic [9:0]  e2;
  // stage 3
  logic        v3, sp3, sgn3;
  word_t       spv3;
  logic [47:0] m3;
  logic [4:0]  sh3;
  logic [30:0] base3;

  word_t       a, b, spec;
  logic        isspec;
  logic [30:0] ma, mb;
  logic [4:0]  za, zb;
  logic [23:0] na, nb;
  logic [9:0]  ea, eb;
  always_comb begin
    a = in_ch.operand_a;
    b = in_ch.operand_b;
    ma = a[30:0];
    mb = b[30:0];
    isspec = 1'b1;
    spec = '0;
    priority if ({1'b0, ma} > InfBits) spec = a | QuietBit;
    else if ({1'b0, mb} > InfBits) spec = b | QuietBit;
    else if (ma == '0) spec = (b[30:23] == 8'hff) ? DefaultNan : {a[31] ^ b[31], 31'd0};
    else if (mb == '0) spec = (a[30:23] == 8'hff) ? DefaultNan : {a[31] ^ b[31], 31'd0};
    else if ({1'b0, ma} == InfBits || {1'b0, mb} == InfBits)
      spec = {a[31] ^ b[31], InfBits[30:0]};
    else isspec = 1'b0;
    za = lzc24({1'b0, a[22:0]});
    zb = lzc24({1'b0, b[22:0]});
    // subnormal: shift left by lz, exponent field 1 - lz
    if (a[30:23] == 8'd0) begin
      na = {1'b0, a[22:0]} << za;
      ea = 10'd1 - {5'd0, za};
    end else begin
      na = {1'b1, a[22:0]};
      ea = {2'd0, a[30:23]};
    end
    if (b[30:23] == 8'd0) begin
      nb = {1'b0, b[22:0]} << zb;
      eb = 10'd1 - {5'd0, zb};
    end else begin
      nb = {1'b1, b[22:0]};
      eb = {2'd0, b[30:23]};
    end
  end

  // stage 3 comb: normalize product, pick shift
  logic [47:0] mn;
  logic [9:0]  en, s;
  logic        ovf;
  logic [4:0]  sh3_n;
  logic [30:0] base_n;
  always_comb begin
    if (m2[47]) begin
      mn = m2;
      en = e2 + 10'd1;
    end else begin
      mn = m2 << 1;
      en = e2;
    end
    s = 10'd1 - en;
    ovf = !en[9] && (en > ExpMaxNorm);
    sh3_n = '0;
    base_n = '0;
    if (!en[9] && en != 10'd0) begin
      base_n = {en[7:0] - 8'd1, 23'd0};
    end else begin
      sh3_n = (s > MaxDenorm) ? MaxDenorm[4:0] : s[4:0];
    end
  end

  // stage 4 comb: shift and round
  logic [47:0] sm, lost;
  logic [31:0] r;
  logic        rnd, stk;
  always_comb begin
    sm = m3 >> sh3;
    lost = m3 & ~({48{1'b1}} << sh3);
    rnd = sm[23];
    stk = (sm[22:0] != '0) || (lost != '0);
    r = {sgn3, base3} + {8'd0, sm[47:24]};
    if (rnd && (stk || sm[24])) r = r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
      out_ch.valid <= v3;
    end
    if (adv) begin
      // advance payload
      sp1 <= isspec; spv1 <= spec; sgn1 <= a[31] ^ b[31];
      sa1 <= na; sb1 <= nb; e1 <= ea + eb - ExpBias;
      sp2 <= sp1; spv2 <= spv1; sgn2 <= sgn1;
      m2 <= sa1 * sb1; e2 <= e1;
      sgn3 <= sgn2; m3 <= mn; sh3 <= sh3_n; base3 <= base_n;
      sp3 <= sp2 || ovf;
      spv3 <= sp2 ? spv2 : {sgn2, InfBits[30:0]};
      out_ch.product <= sp3 ? spv3 : r;
    end
  end

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.product))
    else $error("output changed under stall");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready ##1 adv ##1 adv ##1 adv |=> out_ch.valid)
    else $error("transaction lost in pipeline");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("stall without pending output");
`endif
endmodule
